/* design/negacyclic_poly_arith_mod_q_unit_defines.svh */
// ----------------------------------------------------------------------------
// Negacyclic polynomial unit assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef NEGACYCLIC_POLY_ARITH_MOD_Q_UNIT_DEFINES_SVH
`define NEGACYCLIC_POLY_ARITH_MOD_Q_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define NPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npa assertion failed");
`define NPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npa assertion failed");
`else
`define NPA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/npa_pkg.sv */
// ----------------------------------------------------------------------------
// npa_pkg
// Shared constants, codes and types of the negacyclic polynomial unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npa_pkg;

  localparam int RING_DEGREE = 256;
  localparam int IDX_W       = $clog2(RING_DEGREE);
  localparam int COEF_W      = 24;
  localparam int SUM_W       = COEF_W + 2;
  localparam int KIN_W       = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SUB   = 2'd1;
  localparam logic [1:0] OP_MUL   = 2'd2;
  localparam logic [1:0] OP_SCALE = 2'd3;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALAR  = 2'd2;

  localparam logic [COEF_W-1:0] MODULUS_RST = 24'd3329;
  localparam logic [COEF_W-1:0] SCALAR_RST  = 24'd1;

  // one multiply/reduce token moving down the cell row
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              neg;
    logic [COEF_W-1:0] m;
    logic [COEF_W-1:0] y;
    logic [COEF_W-1:0] r;
    logic [COEF_W-1:0] aux;
  } npa_tok_t;

  function automatic logic [COEF_W-1:0] mod_add(logic [COEF_W-1:0] x,
                                                logic [COEF_W-1:0] y,
                                                logic [COEF_W-1:0] q);
    logic [COEF_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, q}) begin
      s = s - {1'b0, q};
    end
    return s[COEF_W-1:0];
  endfunction

  function automatic logic [COEF_W-1:0] mod_sub(logic [COEF_W-1:0] x,
                                                logic [COEF_W-1:0] y,
                                                logic [COEF_W-1:0] q);
    logic [COEF_W:0] s;
    if (x >= y) begin
      s = {1'b0, x} - {1'b0, y};
    end else begin
      s = {1'b0, x} + {1'b0, q} - {1'b0, y};
    end
    return s[COEF_W-1:0];
  endfunction

endpackage

/* design/npa_ram.sv */
// ----------------------------------------------------------------------------
// npa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/npa_cell.sv */
// ----------------------------------------------------------------------------
// npa_cell
// One step of MSB-first interleaved modular multiplication: r = 2r + bit*m mod q.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npa_cell
  import npa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [COEF_W-1:0] q,
  input  npa_tok_t          tok_i,
  output npa_tok_t          tok_o
);

  npa_tok_t          tok_r;
  logic [SUM_W-1:0]  t;
  logic [SUM_W-1:0]  q1;
  logic [SUM_W-1:0]  q2;
  logic [SUM_W-1:0]  red;

  always_comb begin
    q1 = SUM_W'(q);
    q2 = {1'b0, q, 1'b0};
    t  = SUM_W'({tok_i.r, 1'b0}) + (tok_i.y[COEF_W-1] ? SUM_W'(tok_i.m) : '0);
    if (t >= q2) begin
      red = t - q2;
    end else if (t >= q1) begin
      red = t - q1;
    end else begin
      red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_i.valid;
    end
    tok_r.last <= tok_i.last;
    tok_r.neg  <= tok_i.neg;
    tok_r.m    <= tok_i.m;
    tok_r.y    <= {tok_i.y[COEF_W-2:0], 1'b0};
    tok_r.r    <= red[COEF_W-1:0];
    tok_r.aux  <= tok_i.aux;
  end

  assign tok_o = tok_r;

endmodule

/* design/npa_acc.sv */
// ----------------------------------------------------------------------------
// npa_acc
// Final combine: add/sub of reduced pair, scalar pass, or negacyclic sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npa_acc
  import npa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [COEF_W-1:0] q,
  input  logic [1:0]        op,
  input  npa_tok_t          tok,
  output logic              res_valid,
  output logic [COEF_W-1:0] res_value
);

  logic [COEF_W-1:0] acc_r;
  logic [COEF_W-1:0] acc_nxt;
  logic [COEF_W-1:0] sum;

  always_comb begin
    sum = tok.neg ? mod_sub(acc_r, tok.r, q) : mod_add(acc_r, tok.r, q);
    case (op)
      OP_ADD:   res_value = mod_add(tok.aux, tok.r, q);
      OP_SUB:   res_value = mod_sub(tok.aux, tok.r, q);
      OP_MUL:   res_value = sum;
      OP_SCALE: res_value = tok.r;
      default:  res_value = tok.r;
    endcase
    acc_nxt = acc_r;
    if (tok.valid) begin
      acc_nxt = tok.last ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign res_valid = tok.valid && tok.last;

endmodule

/* design/negacyclic_poly_arith_mod_q_unit.sv */
// Load item: a and b reduced mod q through the cell row, then written to the operand RAMs.
// Read item: add/sub/scalar result after one pass through the cell row; negacyclic multiply issues
// one term a cycle from the operand RAMs into a 48-cell row and accumulates the products.
// One item in flight at a time; input stalls until the item completes and its result is taken.
// Reset clears control and restores config defaults; operand RAMs hold no reset.
// ----------------------------------------------------------------------------
// negacyclic_poly_arith_mod_q_unit
// Polynomial add/sub/scalar/negacyclic multiply mod q over a row of mulmod cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "negacyclic_poly_arith_mod_q_unit_defines.svh"

module negacyclic_poly_arith_mod_q_unit
  import npa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [KIN_W-1:0]     in_coef_index,
  input  logic [COEF_W-1:0]    in_coef_a,
  input  logic [COEF_W-1:0]    in_coef_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIN_W-1:0]     out_result_index,
  output logic [COEF_W-1:0]    out_result_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } seq_st_t;

  seq_st_t           seq_st_r, seq_st_nxt;
  logic [COEF_W-1:0] modulus_r, scalar_r, q;
  logic [1:0]        op_r;
  logic [KIN_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, kk, last_i, addr_a, addr_b;
  logic [IDX_W:0]    bdiff;
  logic              is_mul, mul_rd, in_acc, k_ok, issue;
  logic              ld_r, ld_nxt;
  logic [COEF_W-1:0] ld_a_r, ld_b_r;
  logic              iss_v_r, iss_last_r, iss_neg_r;
  logic              out_valid_r, out_valid_nxt;
  logic [KIN_W-1:0]  out_idx_r, out_idx_nxt;
  logic [COEF_W-1:0] out_val_r, out_val_nxt;
  logic [COEF_W-1:0] ram_a_rd, ram_b_rd;
  logic              ram_we;
  logic              res_valid;
  logic [COEF_W-1:0] res_value;
  npa_tok_t          tok_w [0:2*COEF_W];
  npa_tok_t          glue;

  assign cfg_ready = 1'b1;
  assign q         = (modulus_r < COEF_W'(2)) ? COEF_W'(2) : modulus_r;
  assign is_mul    = (op_r == OP_MUL);
  assign mul_rd    = is_mul && !ld_r;
  assign in_stall  = (seq_st_r != ST_IDLE) || out_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign k_ok      = 32'(in_coef_index) < RING_DEGREE;
  assign ram_we    = res_valid && ld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      op_r      <= OP_MUL;
      scalar_r  <= SCALAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODULUS: modulus_r <= cfg_data;
        CFG_OP:      op_r      <= cfg_data[1:0];
        CFG_SCALAR:  scalar_r  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // item sequencer
  always_comb begin
    kk     = IDX_W'(k_r);
    last_i = mul_rd ? IDX_W'(RING_DEGREE - 1) : '0;
    bdiff  = {1'b0, kk} - {1'b0, i_r};
    if (i_r > kk) begin
      bdiff = bdiff + (IDX_W + 1)'(RING_DEGREE);
    end
    addr_a = mul_rd ? i_r : kk;
    addr_b = mul_rd ? bdiff[IDX_W-1:0] : kk;
    issue  = (seq_st_r == ST_ISSUE);

    seq_st_nxt    = seq_st_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    ld_nxt        = ld_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (seq_st_r)
      ST_IDLE: begin
        if (in_acc) begin
          k_nxt  = in_coef_index;
          i_nxt  = '0;
          ld_nxt = (in_opcode == OPC_LOAD);
          if (k_ok) begin
            seq_st_nxt = ST_ISSUE;
          end else if (in_opcode == OPC_READ) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = in_coef_index;
            out_val_nxt   = '0;
          end
        end
      end
      ST_ISSUE: begin
        i_nxt = i_r + IDX_W'(1);
        if (i_r == last_i) begin
          seq_st_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (res_valid) begin
          seq_st_nxt = ST_IDLE;
          if (!ld_r) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = k_r;
            out_val_nxt   = res_value;
          end
        end
      end
      default: seq_st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_st_r    <= ST_IDLE;
      out_valid_r <= 1'b0;
      iss_v_r     <= 1'b0;
      i_r         <= '0;
    end else begin
      seq_st_r    <= seq_st_nxt;
      out_valid_r <= out_valid_nxt;
      iss_v_r     <= issue;
      i_r         <= i_nxt;
    end
    k_r        <= k_nxt;
    ld_r       <= ld_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    iss_last_r <= (i_r == last_i);
    iss_neg_r  <= mul_rd && (i_r > kk);
    if (in_acc) begin
      ld_a_r <= in_coef_a;
      ld_b_r <= in_coef_b;
    end
  end

  npa_ram #(.WIDTH(COEF_W), .DEPTH(RING_DEGREE)) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(k_r)),
    .wdata (tok_w[2*COEF_W].aux),
    .raddr (addr_a),
    .rdata (ram_a_rd)
  );

  npa_ram #(.WIDTH(COEF_W), .DEPTH(RING_DEGREE)) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(k_r)),
    .wdata (tok_w[2*COEF_W].r),
    .raddr (addr_b),
    .rdata (ram_b_rd)
  );

  // first half reduces a; second half multiplies by b/s or reduces b
  always_comb begin
    tok_w[0].valid = iss_v_r;
    tok_w[0].last  = iss_last_r;
    tok_w[0].neg   = iss_neg_r;
    tok_w[0].m     = COEF_W'(1);
    tok_w[0].y     = ld_r ? ld_a_r : ram_a_rd;
    tok_w[0].r     = '0;
    if (ld_r) begin
      tok_w[0].aux = ld_b_r;
    end else begin
      tok_w[0].aux = (op_r == OP_SCALE) ? scalar_r : ram_b_rd;
    end
  end

  always_comb begin
    glue       = tok_w[COEF_W];
    glue.m     = (!ld_r && (is_mul || (op_r == OP_SCALE))) ? tok_w[COEF_W].r : COEF_W'(1);
    glue.y     = tok_w[COEF_W].aux;
    glue.r     = '0;
    glue.aux   = tok_w[COEF_W].r;
  end

  genvar j;
  generate
    for (j = 0; j < 2 * COEF_W; j++) begin : g_cell
      if (j == COEF_W) begin : g_mid
        npa_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .q     (q),
          .tok_i (glue),
          .tok_o (tok_w[j+1])
        );
      end else begin : g_row
        npa_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .q     (q),
          .tok_i (tok_w[j]),
          .tok_o (tok_w[j+1])
        );
      end
    end
  endgenerate

  npa_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (q),
    .op        (op_r),
    .tok       (tok_w[2*COEF_W]),
    .res_valid (res_valid),
    .res_value (res_value)
  );

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_result_value = out_val_r;

  `NPA_ASSERT_IMPL(a_res_in_wait, clk, rst_n, res_valid, seq_st_r == ST_WAIT)
  `NPA_ASSERT_IMPL(a_row_busy, clk, rst_n, tok_w[2*COEF_W].valid, seq_st_r != ST_IDLE)
  `NPA_ASSERT_NEXT(a_done_out, clk, rst_n, res_valid && !ld_r, out_valid_r && (seq_st_r == ST_IDLE))

endmodule
